[rtl/etok_pkg.sv]
// shared types, character codes and the function-name table for the expression tokenizer
package etok_pkg;

  typedef enum logic [3:0] {
    KIND_BEGIN = 4'd0,
    KIND_END   = 4'd1,
    KIND_ADD   = 4'd2,
    KIND_SUB   = 4'd3,
    KIND_MUL   = 4'd4,
    KIND_DIV   = 4'd5,
    KIND_POW   = 4'd6,
    KIND_OPEN  = 4'd7,
    KIND_CLOSE = 4'd8,
    KIND_VAR   = 4'd9,
    KIND_FUNC  = 4'd10
  } kind_t;

  typedef enum logic [2:0] {
    PRIO_START_END = 3'd0,
    PRIO_ADD_SUB   = 3'd1,
    PRIO_MUL_DIV   = 3'd2,
    PRIO_BRACKET   = 3'd3,
    PRIO_VARIABLE  = 3'd4,
    PRIO_FUNC_UNARY = 3'd5
  } prio_t;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_CARET = 8'h5e;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;

  localparam int NUM_FUNCS = 13;
  localparam int SLOTS     = 3;

  // names packed first character in the low byte
  localparam logic [31:0] FUNC_TEXT [NUM_FUNCS] = '{
    32'h006e6973, // sin
    32'h00736f63, // cos
    32'h006e6174, // tan
    32'h00746f63, // cot
    32'h6e617461, // atan
    32'h746f6361, // acot
    32'h6e697361, // asin
    32'h736f6361, // acos
    32'h00006e6c, // ln
    32'h0000676c, // lg
    32'h00676f6c, // log
    32'h74727173, // sqrt
    32'h00776f70  // pow
  };

  localparam logic [7:0] FUNC_LEN [NUM_FUNCS] = '{
    8'd3, 8'd3, 8'd3, 8'd3, 8'd4, 8'd4, 8'd4, 8'd4, 8'd2, 8'd2, 8'd3, 8'd4, 8'd3
  };

  typedef struct packed {
    kind_t       kind;
    prio_t       prio;
    logic [63:0] text;
    logic [7:0]  text_len;
    logic        overflow;
    logic        end_of_expr;
  } token_t;

  // up to three tokens caused by one request, in emission order
  typedef struct packed {
    token_t [SLOTS-1:0] slot;
    logic   [SLOTS-1:0] valid;
  } tok_group_t;

  // bytes above the fourth are zero whenever the length matches a table entry
  function automatic logic is_function(input logic [31:0] low_text, input logic [7:0] len);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < NUM_FUNCS; i++) begin
      if (FUNC_LEN[i] == len && FUNC_TEXT[i] == low_text) hit = 1'b1;
    end
    return hit;
  endfunction

endpackage

[rtl/etok_lex.sv]
// combinational lexing step: tokens caused by one request and the next name state
module etok_lex
  import etok_pkg::*;
#(
  parameter int MAX_NAME_CHARS = 8
) (
  input  logic                        in_expr,
  input  logic [8*MAX_NAME_CHARS-1:0] name_buffer,
  input  logic [7:0]                  name_length,
  input  kind_t                       previous_kind,
  input  logic [7:0]                  ch,
  input  logic                        no_char,
  input  logic                        last,
  output tok_group_t                  group,
  output logic                        in_expr_next,
  output logic [8*MAX_NAME_CHARS-1:0] name_buffer_next,
  output logic [7:0]                  name_length_next,
  output kind_t                       previous_kind_next
);

  localparam int NB = 8 * MAX_NAME_CHARS;

  logic          begin_tok, is_op, name_ch, flush_op, flush_last, ovf, is_fn, unary;
  logic [NB-1:0] buf_eff, buf_app, buf_src;
  logic [7:0]    len_eff, len_app, len_src;
  kind_t         op_kind;
  prio_t         op_prio;
  token_t        t_begin, t_name, t_op, t_end;

  always_comb begin
    op_kind = KIND_BEGIN;
    op_prio = PRIO_START_END;
    is_op   = 1'b0;
    if (!no_char) begin
      unique case (ch)
        CH_PLUS:  begin op_kind = KIND_ADD;   op_prio = PRIO_ADD_SUB; is_op = 1'b1; end
        CH_MINUS: begin op_kind = KIND_SUB;   op_prio = PRIO_ADD_SUB; is_op = 1'b1; end
        CH_STAR:  begin op_kind = KIND_MUL;   op_prio = PRIO_MUL_DIV; is_op = 1'b1; end
        CH_SLASH: begin op_kind = KIND_DIV;   op_prio = PRIO_MUL_DIV; is_op = 1'b1; end
        CH_CARET: begin op_kind = KIND_POW;   op_prio = PRIO_MUL_DIV; is_op = 1'b1; end
        CH_OPEN:  begin op_kind = KIND_OPEN;  op_prio = PRIO_BRACKET; is_op = 1'b1; end
        CH_CLOSE: begin op_kind = KIND_CLOSE; op_prio = PRIO_BRACKET; is_op = 1'b1; end
        default:  is_op = 1'b0;
      endcase
    end
    name_ch = !no_char && !is_op && (ch != CH_SPACE);

    // opening an expression clears the name and restarts at begin
    begin_tok = !in_expr;
    buf_eff   = begin_tok ? '0 : name_buffer;
    len_eff   = begin_tok ? 8'd0 : name_length;

    for (int i = 0; i < MAX_NAME_CHARS; i++) begin
      buf_app[8*i +: 8] = (name_ch && len_eff == 8'(i)) ? ch : buf_eff[8*i +: 8];
    end
    len_app = (name_ch && len_eff != 8'hff) ? len_eff + 8'd1 : len_eff;

    flush_op   = is_op && (len_eff != 8'd0);
    flush_last = last && !is_op && (len_app != 8'd0);

    buf_src = is_op ? buf_eff : buf_app;
    len_src = is_op ? len_eff : len_app;
    ovf     = len_src > 8'(MAX_NAME_CHARS);
    is_fn   = !ovf && is_function(buf_src[31:0], len_src);

    // unary sign only straight after begin or an open bracket
    unary = !flush_op && (begin_tok || previous_kind == KIND_BEGIN || previous_kind == KIND_OPEN)
            && (op_kind == KIND_ADD || op_kind == KIND_SUB);

    t_begin = '{kind: KIND_BEGIN, prio: PRIO_START_END, text: 64'd0, text_len: 8'd0,
                overflow: 1'b0, end_of_expr: 1'b0};
    t_end   = '{kind: KIND_END, prio: PRIO_START_END, text: 64'd0, text_len: 8'd0,
                overflow: 1'b0, end_of_expr: 1'b1};
    t_name  = '{kind: is_fn ? KIND_FUNC : KIND_VAR,
                prio: is_fn ? PRIO_FUNC_UNARY : PRIO_VARIABLE,
                text: 64'(buf_src), text_len: len_src, overflow: ovf, end_of_expr: 1'b0};
    t_op    = '{kind: op_kind, prio: unary ? PRIO_FUNC_UNARY : op_prio,
                text: {56'd0, ch}, text_len: 8'd1, overflow: 1'b0, end_of_expr: 1'b0};

    group.slot[0]  = begin_tok ? t_begin : t_name;
    group.valid[0] = begin_tok || flush_op;
    group.slot[1]  = is_op ? t_op : t_name;
    group.valid[1] = is_op || flush_last;
    group.slot[2]  = t_end;
    group.valid[2] = last;

    in_expr_next     = !last;
    name_buffer_next = (last || is_op) ? '0 : buf_app;
    name_length_next = (last || is_op) ? 8'd0 : len_app;
    if (last) begin
      previous_kind_next = KIND_BEGIN;
    end else if (is_op) begin
      previous_kind_next = op_kind;
    end else if (begin_tok) begin
      previous_kind_next = KIND_BEGIN;
    end else begin
      previous_kind_next = previous_kind;
    end
  end

endmodule

[rtl/etok_result_buf.sv]
// result register for one request's tokens; hands out one per cycle while out_ready is high
module etok_result_buf
  import etok_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  tok_group_t group,
  output logic       can_load,
  output logic       out_valid,
  input  logic       out_ready,
  output token_t     token
);

  token_t [SLOTS-1:0] slots;
  logic   [SLOTS-1:0] mask;
  logic   [SLOTS-1:0] sel;

  // lowest pending slot goes first
  assign sel       = mask & (~mask + 3'd1);
  assign out_valid = |mask;
  assign can_load  = (mask == '0) || (out_ready && ((mask & (mask - 3'd1)) == '0));

  always_comb begin
    if (mask[0]) begin
      token = slots[0];
    end else if (mask[1]) begin
      token = slots[1];
    end else begin
      token = slots[2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else if (load) begin
      mask <= group.valid;
    end else if (out_valid && out_ready) begin
      mask <= mask & ~sel;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slots <= group.slot;
    end
  end

endmodule

[rtl/expression_tokenizer_unit.sv]
// streaming lexer for arithmetic expressions: one byte in, begin/operator/name/end tokens out
//
// Input channel (in_valid/in_ready) takes one byte per request with no_char and last flags.
// The first request of an expression yields a begin token; last flushes any pending name
// and yields the end token (end_of_expr set). Spaces are dropped, operators are single
// tokens, other bytes build names that are checked against the function table.
// Output channel (out_valid/out_ready) gives one token per cycle while out_ready is high.
// A request taken into the input register is lexed from there and loaded into the result
// register, from which its first token can be taken. A request causes zero to three
// tokens; the result register drains one token per cycle while out_ready is high, so a
// new request is taken every cycle as long as each causes at most one token and the
// receiver keeps up. A request with two or more tokens stalls the input until only one
// of them is left pending. When the receiver stalls the result register
// holds its tokens, the input register fills and in_ready drops. Reset empties both
// registers and closes any open expression, so the next request starts a new one with a
// begin token.
module expression_tokenizer_unit
  import etok_pkg::*;
#(
  parameter int MAX_NAME_CHARS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  ch,
  input  logic        no_char,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  kind,
  output logic [2:0]  priority_res,
  output logic [63:0] text,
  output logic [7:0]  text_len,
  output logic        overflow,
  output logic        end_of_expr
);

  localparam int NB = 8 * MAX_NAME_CHARS;

  logic          req_valid;
  logic [7:0]    req_ch;
  logic          req_no_char;
  logic          req_last;

  logic          in_expr, in_expr_next;
  logic [NB-1:0] name_buffer, name_buffer_next;
  logic [7:0]    name_length, name_length_next;
  kind_t         previous_kind, previous_kind_next;

  tok_group_t    group;
  token_t        token;
  logic          can_load, load;

  assign load     = req_valid && can_load;
  assign in_ready = !req_valid || can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_ready) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_ch      <= ch;
      req_no_char <= no_char;
      req_last    <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_expr       <= 1'b0;
      name_buffer   <= '0;
      name_length   <= 8'd0;
      previous_kind <= KIND_BEGIN;
    end else if (load) begin
      in_expr       <= in_expr_next;
      name_buffer   <= name_buffer_next;
      name_length   <= name_length_next;
      previous_kind <= previous_kind_next;
    end
  end

  etok_lex #(
    .MAX_NAME_CHARS(MAX_NAME_CHARS)
  ) u_lex (
    .in_expr           (in_expr),
    .name_buffer       (name_buffer),
    .name_length       (name_length),
    .previous_kind     (previous_kind),
    .ch                (req_ch),
    .no_char           (req_no_char),
    .last              (req_last),
    .group             (group),
    .in_expr_next      (in_expr_next),
    .name_buffer_next  (name_buffer_next),
    .name_length_next  (name_length_next),
    .previous_kind_next(previous_kind_next)
  );

  etok_result_buf u_res (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .group    (group),
    .can_load (can_load),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .token    (token)
  );

  assign kind         = token.kind;
  assign priority_res = token.prio;
  assign text         = token.text;
  assign text_len     = token.text_len;
  assign overflow     = token.overflow;
  assign end_of_expr  = token.end_of_expr;

endmodule
